[sv/mrcs_pkg.sv]
`default_nettype none

package mrcs_pkg;

   localparam int DEF_MAX_CHAINS = 4;
   localparam int DEF_CAPACITY   = 32;
   localparam int DEF_ELEM_WIDTH = 64;

   localparam int OPCODE_W      = 3;
   localparam int CHAIN_IDX_W   = 2;
   localparam int ELEM_IDX_W    = 5;
   localparam int DATA_W        = 64;
   localparam int STATUS_W      = 2;
   localparam int COUNT_W       = 6;
   localparam int CSR_IDX_W     = 1;
   localparam int CSR_DATA_W    = 6;
   localparam int CHAIN_COUNT_W = 3;
   localparam int CHAIN_SLOTS   = 1 << CHAIN_IDX_W;

   localparam int RST_CHAIN_LENGTH = 20;
   localparam int RST_CHAIN_COUNT  = 1;

   typedef logic [OPCODE_W-1:0]  opcode_type;
   typedef logic [STATUS_W-1:0]  status_type;
   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   localparam opcode_type OP_PUSH        = 3'd0;
   localparam opcode_type OP_CLEAR_CHAIN = 3'd1;
   localparam opcode_type OP_CLEAR_ALL   = 3'd2;
   localparam opcode_type OP_WRITE       = 3'd3;
   localparam opcode_type OP_READ        = 3'd4;
   localparam opcode_type OP_COUNT       = 3'd5;

   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_BAD_CHAIN = 2'd1;
   localparam status_type STATUS_EMPTY     = 2'd2;

   localparam csr_index_type REG_CHAIN_LENGTH = 1'b0;
   localparam csr_index_type REG_CHAIN_COUNT  = 1'b1;

endpackage

`default_nettype wire

[sv/multi_ring_chain_store_unit.sv]
`default_nettype none

// A bank of ring buffers, one per chain, sharing one element store memory. Push,
// clear-chain, clear-all, count, unknown opcodes and any word rejected for a bad
// chain or an empty chain answer in the cycle after start, and busy stays low, so
// a new word may follow in the next cycle. A write or read at an offset keeps busy high
// while a five-step shift-and-subtract unit reduces the offset modulo chain_length and
// adds the base; a read then also passes the store's registered read port.
// Each result is shown for exactly one cycle with rsp_valid and cannot be held off.
// Writing either configuration register empties every chain.
module multi_ring_chain_store_unit #(
   parameter int MAX_CHAINS = mrcs_pkg::DEF_MAX_CHAINS,
   parameter int CAPACITY   = mrcs_pkg::DEF_CAPACITY,
   parameter int ELEM_WIDTH = mrcs_pkg::DEF_ELEM_WIDTH
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [mrcs_pkg::OPCODE_W-1:0]     req_opcode,
   input  wire logic [mrcs_pkg::CHAIN_IDX_W-1:0]  req_chain_index,
   input  wire logic [mrcs_pkg::ELEM_IDX_W-1:0]   req_element_index,
   input  wire logic [mrcs_pkg::DATA_W-1:0]       req_element_data,
   output logic                                   rsp_valid,
   output logic      [mrcs_pkg::STATUS_W-1:0]     rsp_status,
   output logic      [mrcs_pkg::DATA_W-1:0]       rsp_read_data,
   output logic      [mrcs_pkg::COUNT_W-1:0]      rsp_element_count,
   input  wire logic                              csr_wr_en,
   input  wire logic [mrcs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [mrcs_pkg::CSR_DATA_W-1:0]   csr_wr_data
);

   import mrcs_pkg::*;

   localparam int SLOT_W  = $clog2(CAPACITY);
   localparam int LEN_W   = $clog2(CAPACITY + 1);
   localparam int CNT_W   = LEN_W + 1;
   localparam int DEPTH   = MAX_CHAINS * CAPACITY;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int RST_LEN = RST_CHAIN_LENGTH > CAPACITY ? CAPACITY : RST_CHAIN_LENGTH;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_WRAP = 3'b010,
      S_READ = 3'b100
   } state_type;

   state_type              state_ff, state_in;
   logic [LEN_W-1:0]       len_ff, len_in;
   logic [CHAIN_COUNT_W-1:0] chains_ff, chains_in;
   logic [SLOT_W-1:0]      newest_ff [CHAIN_SLOTS];
   logic [SLOT_W-1:0]      newest_in [CHAIN_SLOTS];
   logic [SLOT_W-1:0]      oldest_ff [CHAIN_SLOTS];
   logic [SLOT_W-1:0]      oldest_in [CHAIN_SLOTS];
   logic [CHAIN_SLOTS-1:0] occupied_ff, occupied_in;

   logic                   is_read_ff, is_read_in;
   logic [CHAIN_IDX_W-1:0] chain_ff, chain_in;
   logic [ELEM_WIDTH-1:0]  data_ff, data_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]      rsp_data_ff, rsp_data_in;
   logic [COUNT_W-1:0]     rsp_count_ff, rsp_count_in;

   logic                   ram_we;
   logic [ADDR_W-1:0]      ram_waddr;
   logic [ELEM_WIDTH-1:0]  ram_wdata;
   logic [ADDR_W-1:0]      ram_raddr;
   logic [ELEM_WIDTH-1:0]  ram_rdata;

   logic                   wrap_start;
   logic                   wrap_done;
   logic [SLOT_W-1:0]      wrap_slot;

   mrcs_ram #(
      .WIDTH (ELEM_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   mrcs_wrap #(
      .CAPACITY (CAPACITY)
   ) u_wrap (
      .clock  (clock),
      .reset  (reset),
      .start  (wrap_start),
      .offset (req_element_index),
      .base   (newest_ff[chain_ff]),
      .length (len_ff),
      .done   (wrap_done),
      .slot   (wrap_slot)
   );

   always_comb begin
      logic [SLOT_W-1:0] cur_nw;
      logic [SLOT_W-1:0] cur_od;
      logic [SLOT_W-1:0] nw;
      logic [SLOT_W-1:0] od;
      logic [SLOT_W-1:0] last_slot;
      logic              bad_chain;
      logic [ADDR_W-1:0] item_addr;
      logic [CNT_W-1:0]  count;

      state_in      = state_ff;
      len_in        = len_ff;
      chains_in     = chains_ff;
      newest_in     = newest_ff;
      oldest_in     = oldest_ff;
      occupied_in   = occupied_ff;
      is_read_in    = is_read_ff;
      chain_in      = chain_ff;
      data_in       = data_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = STATUS_OK;
      rsp_data_in   = '0;
      rsp_count_in  = '0;
      wrap_start    = 1'b0;

      cur_nw    = newest_ff[req_chain_index];
      cur_od    = oldest_ff[req_chain_index];
      last_slot = SLOT_W'(len_ff - 1'b1);
      bad_chain = (CHAIN_COUNT_W'(req_chain_index) >= chains_ff)
                  || (int'(req_chain_index) >= MAX_CHAINS);
      nw        = (cur_nw == '0) ? last_slot : cur_nw - 1'b1;
      od        = cur_od;
      if (!occupied_ff[req_chain_index]) begin
         nw = last_slot;
         od = last_slot;
      end else if (nw == cur_od) begin
         od = (cur_od == '0) ? last_slot : cur_od - 1'b1;
      end
      if (cur_od < cur_nw) begin
         count = CNT_W'(cur_od) + CNT_W'(len_ff) + 1'b1 - CNT_W'(cur_nw);
      end else begin
         count = CNT_W'(cur_od) - CNT_W'(cur_nw) + 1'b1;
      end

      item_addr = ADDR_W'(int'(chain_ff) * CAPACITY + int'(wrap_slot));
      ram_raddr = item_addr;
      ram_we    = 1'b0;
      ram_waddr = ADDR_W'(int'(req_chain_index) * CAPACITY + int'(nw));
      ram_wdata = ELEM_WIDTH'(req_element_data);

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               rsp_valid_in = 1'b1;
               if (req_opcode == OP_CLEAR_ALL) begin
                  occupied_in = '0;
                  for (int i = 0; i < CHAIN_SLOTS; i++) begin
                     newest_in[i] = '0;
                     oldest_in[i] = '0;
                  end
               end else if (req_opcode > OP_COUNT) begin
                  rsp_status_in = STATUS_OK;
               end else if (bad_chain) begin
                  rsp_status_in = STATUS_BAD_CHAIN;
               end else begin
                  unique case (req_opcode) inside
                     OP_PUSH: begin
                        ram_we                       = 1'b1;
                        newest_in[req_chain_index]   = nw;
                        oldest_in[req_chain_index]   = od;
                        occupied_in[req_chain_index] = 1'b1;
                     end
                     OP_CLEAR_CHAIN: begin
                        newest_in[req_chain_index]   = '0;
                        oldest_in[req_chain_index]   = '0;
                        occupied_in[req_chain_index] = 1'b0;
                     end
                     OP_WRITE, OP_READ: begin
                        if (!occupied_ff[req_chain_index]) begin
                           rsp_status_in = STATUS_EMPTY;
                        end else begin
                           rsp_valid_in = 1'b0;
                           wrap_start   = 1'b1;
                           is_read_in   = (req_opcode == OP_READ);
                           chain_in     = req_chain_index;
                           data_in      = ELEM_WIDTH'(req_element_data);
                           state_in     = S_WRAP;
                        end
                     end
                     OP_COUNT: begin
                        if (occupied_ff[req_chain_index]) begin
                           rsp_count_in = COUNT_W'(count);
                        end
                     end
                     default: begin
                        rsp_status_in = STATUS_OK;
                     end
                  endcase
               end
            end
         end
         S_WRAP: begin
            if (wrap_done) begin
               if (is_read_ff) begin
                  state_in = S_READ;
               end else begin
                  ram_we       = 1'b1;
                  ram_waddr    = item_addr;
                  ram_wdata    = data_ff;
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
            end
         end
         S_READ: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = DATA_W'(ram_rdata);
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_wr_en) begin
         occupied_in = '0;
         for (int i = 0; i < CHAIN_SLOTS; i++) begin
            newest_in[i] = '0;
            oldest_in[i] = '0;
         end
         unique case (csr_index)
            REG_CHAIN_LENGTH: begin
               if (csr_wr_data == '0) begin
                  len_in = LEN_W'(1);
               end else if (int'(csr_wr_data) > CAPACITY) begin
                  len_in = LEN_W'(CAPACITY);
               end else begin
                  len_in = LEN_W'(csr_wr_data);
               end
            end
            REG_CHAIN_COUNT: begin
               if (CHAIN_COUNT_W'(csr_wr_data) == '0) begin
                  chains_in = CHAIN_COUNT_W'(1);
               end else if (int'(CHAIN_COUNT_W'(csr_wr_data)) > MAX_CHAINS) begin
                  chains_in = CHAIN_COUNT_W'(MAX_CHAINS);
               end else begin
                  chains_in = CHAIN_COUNT_W'(csr_wr_data);
               end
            end
            default: begin
               len_in = len_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= LEN_W'(RST_LEN);
         chains_ff    <= CHAIN_COUNT_W'(RST_CHAIN_COUNT);
         occupied_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHAIN_SLOTS; i++) begin
            newest_ff[i] <= '0;
            oldest_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         chains_ff    <= chains_in;
         occupied_ff  <= occupied_in;
         rsp_valid_ff <= rsp_valid_in;
         newest_ff    <= newest_in;
         oldest_ff    <= oldest_in;
      end
      is_read_ff <= is_read_in;
      chain_ff   <= chain_in;
      data_ff    <= data_in;
      if (rsp_valid_in) begin
         rsp_status_ff <= rsp_status_in;
         rsp_data_ff   <= rsp_data_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_read_data     = rsp_data_ff;
   assign rsp_element_count = rsp_count_ff;

   a_wrap_done_in_wrap: assert property (@(posedge clock) disable iff (reset)
      wrap_done |-> (state_ff == S_WRAP))
      else $error("offset reduction finished outside the wrap state");

   a_read_answers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |=> rsp_valid_ff)
      else $error("read did not produce a word");

   a_clear_all_empties: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_opcode == OP_CLEAR_ALL) |=> (occupied_ff == '0))
      else $error("clear all left a chain occupied");

   a_newest_in_range: assert property (@(posedge clock) disable iff (reset)
      occupied_ff[0] |-> (LEN_W'(newest_ff[0]) < len_ff))
      else $error("newest slot of chain zero beyond chain length");

endmodule

`default_nettype wire

[sv/mrcs_ram.sv]
`default_nettype none

module mrcs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

[sv/mrcs_wrap.sv]
`default_nettype none

module mrcs_wrap #(
   parameter int CAPACITY = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic [mrcs_pkg::ELEM_IDX_W-1:0]     offset,
   input  wire logic [$clog2(CAPACITY)-1:0]         base,
   input  wire logic [$clog2(CAPACITY+1)-1:0]       length,
   output logic                                     done,
   output logic      [$clog2(CAPACITY)-1:0]         slot
);

   import mrcs_pkg::*;

   localparam int SLOT_W = $clog2(CAPACITY);
   localparam int LEN_W  = $clog2(CAPACITY + 1);
   localparam int STEP_W = $clog2(ELEM_IDX_W + 1);

   logic                  active_ff, active_in;
   logic                  finish_ff, finish_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [ELEM_IDX_W-1:0] bits_ff, bits_in;
   logic [LEN_W-1:0]      rem_ff, rem_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;

   // One offset bit per cycle is shifted into the remainder; the last cycle adds the base.
   always_comb begin
      logic [LEN_W:0] trial;
      logic [LEN_W:0] sum;
      active_in = active_ff;
      finish_in = 1'b0;
      done_in   = 1'b0;
      step_in   = step_ff;
      bits_in   = bits_ff;
      rem_in    = rem_ff;
      slot_in   = slot_ff;
      trial     = {rem_ff, bits_ff[ELEM_IDX_W-1]};
      sum       = (LEN_W+1)'(base) + (LEN_W+1)'(rem_ff);
      if (start) begin
         active_in = 1'b1;
         step_in   = STEP_W'(ELEM_IDX_W);
         bits_in   = offset;
         rem_in    = '0;
      end else if (active_ff) begin
         if (trial >= {1'b0, length}) begin
            rem_in = LEN_W'(trial - {1'b0, length});
         end else begin
            rem_in = LEN_W'(trial);
         end
         bits_in = bits_ff << 1;
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            active_in = 1'b0;
            finish_in = 1'b1;
         end
      end
      if (finish_ff) begin
         if (sum >= {1'b0, length}) begin
            slot_in = SLOT_W'(sum - {1'b0, length});
         end else begin
            slot_in = SLOT_W'(sum);
         end
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         finish_ff <= 1'b0;
         done_ff   <= 1'b0;
         step_ff   <= '0;
      end else begin
         active_ff <= active_in;
         finish_ff <= finish_in;
         done_ff   <= done_in;
         step_ff   <= step_in;
      end
      bits_ff <= bits_in;
      rem_ff  <= rem_in;
      slot_ff <= slot_in;
   end

   assign done = done_ff;
   assign slot = slot_ff;

endmodule

`default_nettype wire

[dv/tb.sv]
module tb;
   import mrcs_pkg::*;

   typedef struct {
      status_type             status;
      logic [DATA_W-1:0]      read_data;
      logic [COUNT_W-1:0]     element_count;
   } chain_answer_type;

   class chain_bank_tracker;
      logic [DATA_W-1:0] element_store [CHAIN_SLOTS*DEF_CAPACITY];
      bit                slot_written [CHAIN_SLOTS*DEF_CAPACITY];
      int unsigned       newest [CHAIN_SLOTS];
      int unsigned       oldest [CHAIN_SLOTS];
      bit                occupied [CHAIN_SLOTS];
      int unsigned       chain_length;
      int unsigned       chain_count;
      chain_answer_type  pending_answers [$];
      int unsigned       mismatches;

      function new();
         foreach (element_store[i]) begin
            element_store[i] = '0;
            slot_written[i] = 1'b0;
         end
         chain_length = RST_CHAIN_LENGTH > DEF_CAPACITY ? DEF_CAPACITY : RST_CHAIN_LENGTH;
         chain_count = RST_CHAIN_COUNT;
         mismatches = 0;
         empty_chains();
      endfunction

      function void empty_chains();
         foreach (occupied[i]) begin
            occupied[i] = 1'b0;
            newest[i] = 0;
            oldest[i] = 0;
         end
      endfunction

      function int unsigned step_back(int unsigned slot);
         return slot == 0 ? chain_length - 1 : slot - 1;
      endfunction

      function void apply_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
         int unsigned v;
         if (idx == REG_CHAIN_LENGTH) begin
            v = 32'(value);
            if (v < 1) v = 1;
            if (v > DEF_CAPACITY) v = DEF_CAPACITY;
            chain_length = v;
         end else begin
            v = 32'(value[CHAIN_COUNT_W-1:0]);
            if (v < 1) v = 1;
            if (v > DEF_MAX_CHAINS) v = DEF_MAX_CHAINS;
            chain_count = v;
         end
         empty_chains();
      endfunction

      function void note_command(opcode_type op, logic [CHAIN_IDX_W-1:0] c,
                                 logic [ELEM_IDX_W-1:0] off, logic [DATA_W-1:0] data);
         chain_answer_type a;
         int unsigned      nw;
         int unsigned      od;
         int unsigned      slot;
         a.status = STATUS_OK;
         a.read_data = '0;
         a.element_count = '0;
         if (op == OP_CLEAR_ALL) begin
            empty_chains();
         end else if (op > OP_COUNT) begin
         end else if (c >= chain_count) begin
            a.status = STATUS_BAD_CHAIN;
         end else begin
            case (op)
               OP_PUSH: begin
                  if (!occupied[c]) begin
                     nw = chain_length - 1;
                     od = nw;
                     occupied[c] = 1'b1;
                  end else begin
                     nw = step_back(newest[c]);
                     od = oldest[c];
                     if (nw == od) od = step_back(od);
                  end
                  newest[c] = nw;
                  oldest[c] = od;
                  element_store[c*DEF_CAPACITY + nw] = data;
                  slot_written[c*DEF_CAPACITY + nw] = 1'b1;
               end
               OP_CLEAR_CHAIN: begin
                  occupied[c] = 1'b0;
                  newest[c] = 0;
                  oldest[c] = 0;
               end
               OP_WRITE, OP_READ: begin
                  if (!occupied[c]) begin
                     a.status = STATUS_EMPTY;
                  end else begin
                     slot = c*DEF_CAPACITY + (newest[c] + off) % chain_length;
                     if (op == OP_WRITE) begin
                        element_store[slot] = data;
                        slot_written[slot] = 1'b1;
                     end else begin
                        a.read_data = element_store[slot];
                     end
                  end
               end
               default: begin
                  nw = newest[c];
                  od = oldest[c];
                  if (!occupied[c])
                     a.element_count = '0;
                  else if (od < nw)
                     a.element_count = COUNT_W'(od + chain_length + 1 - nw);
                  else
                     a.element_count = COUNT_W'(od - nw + 1);
               end
            endcase
         end
         pending_answers.push_back(a);
      endfunction

      function void check_word(status_type s, logic [DATA_W-1:0] rd,
                               logic [COUNT_W-1:0] cnt);
         chain_answer_type a;
         if (pending_answers.size() == 0) begin
            $error("result word arrived with no command outstanding");
            mismatches++;
            return;
         end
         a = pending_answers.pop_front();
         if (s !== a.status) begin
            $error("status: expected %0d, actual %0d", a.status, s);
            mismatches++;
         end
         if (rd !== a.read_data) begin
            $error("read_data: expected %h, actual %h", a.read_data, rd);
            mismatches++;
         end
         if (cnt !== a.element_count) begin
            $error("element_count: expected %0d, actual %0d", a.element_count, cnt);
            mismatches++;
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [OPCODE_W-1:0]    req_opcode = '0;
   logic [CHAIN_IDX_W-1:0] req_chain_index = '0;
   logic [ELEM_IDX_W-1:0]  req_element_index = '0;
   logic [DATA_W-1:0]      req_element_data = '0;
   logic                   rsp_valid;
   logic [STATUS_W-1:0]    rsp_status;
   logic [DATA_W-1:0]      rsp_read_data;
   logic [COUNT_W-1:0]     rsp_element_count;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wr_data = '0;

   chain_bank_tracker tracker;
   int unsigned       issued;
   int unsigned       gap_ceiling;

   multi_ring_chain_store_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_chain_index   (req_chain_index),
      .req_element_index (req_element_index),
      .req_element_data  (req_element_data),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_read_data     (rsp_read_data),
      .rsp_element_count (rsp_element_count),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #(8 * 400000);
      $display("Verification failed");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         tracker.check_word(rsp_status, rsp_read_data, rsp_element_count);
   end

   task automatic issue(opcode_type op, logic [CHAIN_IDX_W-1:0] c,
                        logic [ELEM_IDX_W-1:0] off, logic [DATA_W-1:0] data);
      int unsigned gap;
      int unsigned slot;
      gap = $urandom_range(0, gap_ceiling);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      // A read must never land on a store entry that was never written.
      if (op == OP_READ && c < tracker.chain_count && tracker.occupied[c]) begin
         slot = c*DEF_CAPACITY + (tracker.newest[c] + off) % tracker.chain_length;
         if (!tracker.slot_written[slot]) off = '0;
      end
      req_opcode <= op;
      req_chain_index <= c;
      req_element_index <= off;
      req_element_data <= data;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      tracker.note_command(op, c, off, data);
      issued++;
   endtask

   task automatic drain();
      start <= 1'b0;
      while (tracker.pending_answers.size() != 0 || busy) @(posedge clock);
   endtask

   task automatic configure(logic [CSR_DATA_W-1:0] length_value,
                            logic [CSR_DATA_W-1:0] count_value);
      csr_wr_en <= 1'b1;
      csr_index <= REG_CHAIN_LENGTH;
      csr_wr_data <= length_value;
      @(posedge clock);
      tracker.apply_csr(REG_CHAIN_LENGTH, length_value);
      csr_index <= REG_CHAIN_COUNT;
      csr_wr_data <= count_value;
      @(posedge clock);
      tracker.apply_csr(REG_CHAIN_COUNT, count_value);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [DATA_W-1:0] random_word();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [CHAIN_IDX_W-1:0] pick_chain();
      if ($urandom_range(0, 9) == 0)
         return CHAIN_IDX_W'($urandom_range(0, CHAIN_SLOTS - 1));
      return CHAIN_IDX_W'($urandom_range(0, tracker.chain_count - 1));
   endfunction

   task automatic random_command();
      int unsigned      r;
      opcode_type       op;
      logic [CHAIN_IDX_W-1:0] c;
      int unsigned      n;
      r = $urandom_range(0, 99);
      if (r < 12) begin
         c = pick_chain();
         n = $urandom_range(1, tracker.chain_length + 3);
         repeat (n) issue(OP_PUSH, c, ELEM_IDX_W'($urandom_range(0, 31)), random_word());
         return;
      end
      r = $urandom_range(0, 99);
      if (r < 30) op = OP_PUSH;
      else if (r < 55) op = OP_READ;
      else if (r < 70) op = OP_WRITE;
      else if (r < 83) op = OP_COUNT;
      else if (r < 88) op = OP_CLEAR_CHAIN;
      else if (r < 90) op = OP_CLEAR_ALL;
      else if (r < 93) op = opcode_type'($urandom_range(OP_COUNT + 1, 7));
      else op = OP_READ;
      issue(op, pick_chain(), ELEM_IDX_W'($urandom_range(0, 31)), random_word());
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] length_value;
      logic [CSR_DATA_W-1:0] count_value;
      int unsigned           target;
      tracker = new();
      issued = 0;
      gap_ceiling = 9;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      issue(OP_COUNT, 0, 0, '0);
      issue(OP_READ, 0, 0, '0);
      issue(OP_WRITE, 0, 31, '1);
      issue(OP_PUSH, 1, 0, '1);
      issue(opcode_type'(6), 0, 0, '0);
      issue(opcode_type'(7), 3, 31, '1);
      issue(OP_PUSH, 0, 0, '1);
      issue(OP_PUSH, 0, 31, '0);
      issue(OP_COUNT, 0, 0, '0);
      issue(OP_READ, 0, 1, '0);
      issue(OP_WRITE, 0, 31, 64'h0123_4567_89ab_cdef);
      issue(OP_READ, 0, 31, '0);
      issue(OP_CLEAR_ALL, 3, 0, '0);
      issue(OP_COUNT, 0, 0, '0);
      drain();
      configure('0, 6'd7);
      issue(OP_PUSH, 3, 0, 64'hfeed_0000_0000_0001);
      issue(OP_PUSH, 3, 0, 64'h8000_0000_0000_0002);
      issue(OP_COUNT, 3, 0, '0);
      issue(OP_READ, 3, 31, '0);
      issue(OP_CLEAR_CHAIN, 3, 0, '0);
      issue(OP_COUNT, 3, 0, '0);
      issue(OP_PUSH, 2, 0, random_word());
      issue(OP_READ, 2, 5, '0);
      drain();
      configure('1, '0);
      issue(OP_PUSH, 0, 0, random_word());
      issue(OP_READ, 3, 0, '0);
      issue(OP_COUNT, 0, 0, '0);

      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin length_value = 6'd32; count_value = 6'd4; end
            1: begin length_value = 6'd1;  count_value = 6'd4; end
            2: begin length_value = 6'd2;  count_value = 6'd3; end
            3: begin length_value = 6'd63; count_value = 6'd2; end
            default: begin
               length_value = CSR_DATA_W'($urandom_range(3, 31));
               count_value = CSR_DATA_W'($urandom_range(0, 63));
            end
         endcase
         drain();
         configure(length_value, count_value);
         gap_ceiling = (phase % 3 == 2) ? 0 : 9;
         target = 25 + (phase + 1) * 212;
         while (issued < target) begin
            random_command();
            if ($urandom_range(0, 59) == 0) drain();
         end
      end

      drain();
      repeat (12) @(posedge clock);
      if (tracker.mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule

[multi_ring_chain_store_unit.f]
sv/mrcs_pkg.sv
sv/mrcs_ram.sv
sv/mrcs_wrap.sv
sv/multi_ring_chain_store_unit.sv
dv/tb.sv
